[rtl/wsfd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsfd_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [31:0] MaxLenReset = 32'hffff_ffff;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [5:0] {
    PhHdr0    = 6'b000001,
    PhHdr1    = 6'b000010,
    PhExtLen  = 6'b000100,
    PhKey     = 6'b001000,
    PhPayload = 6'b010000,
    PhHalted  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEmpty = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
  } cmd_t;

endpackage

[rtl/wsfd_front.sv]
// Header parser: accepts received bytes, tracks frame state and emits result requests.
// Depends on wsfd_pkg.
module wsfd_front import wsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output cmd_t        push_cmd_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [3:0]  ext_q, ext_d;
  logic [63:0] remaining_q, remaining_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [31:0] max_len_q;

  logic        fire;
  logic [6:0]  code;
  logic [63:0] ext_len;
  logic [63:0] chk_len;
  logic        too_big;
  logic        len_done;
  logic        start;
  logic [7:0]  key_sel;

  assign rx_ready_o = push_ready_i;
  assign fire       = rx_valid_i & push_ready_i;

  always_comb begin
    case (key_idx_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
    if (!mask_q) begin
      key_sel = 8'h00;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    opcode_d     = opcode_q;
    mask_d       = mask_q;
    ext_d        = ext_q;
    remaining_d  = remaining_q;
    key_d        = key_q;
    key_idx_d    = key_idx_q;
    len_done     = 1'b0;
    start        = 1'b0;
    push_valid_o = 1'b0;
    push_cmd_o   = '{kind: KindData, raw: 8'h00, key: 8'h00, opcode: opcode_q, last: 1'b0};
    code         = rx_byte_i[6:0];
    ext_len      = {remaining_q[55:0], rx_byte_i};
    chk_len      = (phase_q == PhHdr1) ? {57'd0, code} : ext_len;
    too_big      = (|chk_len[63:32]) || (chk_len[31:0] > max_len_q);

    if (fire) begin
      case (phase_q)
        PhHdr0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          mask_d      = rx_byte_i[7];
          key_d       = '0;
          remaining_d = '0;
          if (code == LenCode16) begin
            ext_d   = ExtBytes16;
            phase_d = PhExtLen;
          end else if (code == LenCode64) begin
            ext_d   = ExtBytes64;
            phase_d = PhExtLen;
          end else begin
            remaining_d = chk_len;
            len_done    = 1'b1;
          end
        end
        PhExtLen: begin
          remaining_d = ext_len;
          ext_d       = ext_q - 4'd1;
          len_done    = (ext_q == 4'd1);
        end
        PhKey: begin
          key_d = {key_q[23:0], rx_byte_i};
          ext_d = ext_q - 4'd1;
          start = (ext_q == 4'd1);
        end
        PhPayload: begin
          push_valid_o    = 1'b1;
          push_cmd_o.raw  = rx_byte_i;
          push_cmd_o.key  = key_sel;
          push_cmd_o.last = (remaining_q == 64'd1);
          remaining_d     = remaining_q - 64'd1;
          key_idx_d       = key_idx_q + 2'd1;
          if (remaining_q == 64'd1) begin
            phase_d = PhHdr0;
          end
        end
        default: ;
      endcase

      if (len_done) begin
        if (too_big) begin
          phase_d         = PhHalted;
          push_valid_o    = 1'b1;
          push_cmd_o.kind = KindError;
          push_cmd_o.last = 1'b1;
        end else if (mask_d) begin
          ext_d   = KeyBytes;
          phase_d = PhKey;
        end else begin
          start = 1'b1;
        end
      end

      if (start) begin
        key_idx_d = 2'd0;
        if (remaining_d == 64'd0) begin
          phase_d         = PhHdr0;
          push_valid_o    = 1'b1;
          push_cmd_o.kind = KindEmpty;
          push_cmd_o.last = 1'b1;
        end else begin
          phase_d = PhPayload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      opcode_q    <= '0;
      mask_q      <= 1'b0;
      ext_q       <= '0;
      remaining_q <= '0;
      key_q       <= '0;
      key_idx_q   <= '0;
      max_len_q   <= MaxLenReset;
    end else begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      mask_q      <= mask_d;
      ext_q       <= ext_d;
      remaining_q <= remaining_d;
      key_q       <= key_d;
      key_idx_q   <= key_idx_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/wsfd_queue.sv]
// Small result request queue between the parser and the output stage.
// Depends on wsfd_pkg.
module wsfd_queue import wsfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = slots_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/wsfd_back.sv]
// Output stage: unmasks payload bytes and holds the result register.
// Depends on wsfd_pkg.
module wsfd_back import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       result_valid_o,
  input  logic       result_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       last_of_frame_o
);

  logic       valid_q;
  kind_e      kind_q;
  logic [7:0] data_q;
  logic [3:0] opcode_q;
  logic       last_q;

  assign cmd_ready_o = !valid_q || result_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      kind_q   <= cmd_i.kind;
      data_q   <= cmd_i.raw ^ cmd_i.key;
      opcode_q <= cmd_i.opcode;
      last_q   <= cmd_i.last;
    end
  end

  assign result_valid_o  = valid_q;
  assign result_kind_o   = kind_q;
  assign payload_byte_o  = data_q;
  assign frame_opcode_o  = opcode_q;
  assign last_of_frame_o = last_q;

endmodule

[rtl/websocket_frame_deframer.sv]
// WebSocket receive frame deframer top level: parser, request queue, output stage.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue, wsfd_back.
//
// Takes one received byte per clock and splits the stream into WebSocket frames: header
// bytes give no result, each payload byte comes out unmasked with the frame opcode and a
// last flag, an empty frame gives one empty-frame result, and a frame longer than the
// max_payload_length register gives one error result after which every byte is taken and
// dropped until reset. A byte is accepted every cycle while the QueueDepth-entry request
// queue has room; the queue and the output register let the input keep flowing for a
// while when the result side stalls. Each result passes the request queue, then the
// output register. Write the limit register only while no frame is in progress.
module websocket_frame_deframer import wsfd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_of_frame_o
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  wsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  wsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_cmd_i    (push_cmd),
    .out_valid_o (pop_valid),
    .out_ready_i (pop_ready),
    .out_cmd_o   (pop_cmd)
  );

  wsfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (pop_ready),
    .cmd_i           (pop_cmd),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_opcode_o  (frame_opcode_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

[rtl/wsfd_checker.sv]
// Port-level checks of the frame deframer, attached to the top level by bind.
// Depends on wsfd_pkg and websocket_frame_deframer.
module wsfd_checker import wsfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic        result_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [3:0]  frame_opcode_o,
  input logic        last_of_frame_o
);

  logic err_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (result_valid_o && result_ready_i && result_kind_o == KindError) begin
      err_seen_q <= 1'b1;
    end
  end

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(result_kind_o) && $stable(payload_byte_o) &&
      $stable(frame_opcode_o) && $stable(last_of_frame_o))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      result_kind_o == KindData || result_kind_o == KindEmpty || result_kind_o == KindError)
    else $error("illegal result kind");

  a_ctrl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o != KindData |-> last_of_frame_o && payload_byte_o == 8'h00)
    else $error("empty or error result not closing the frame");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !result_valid_o)
    else $error("result after frame too large error");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);
